@@ rtl/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types, constants and helpers shared by the dead pixel correction block.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned DATA_W  = 8;   // pixel and mask level width
  localparam int unsigned DIM_W   = 13;  // frame_width / frame_height register width
  localparam int unsigned CNT_W   = 12;  // column and row counters
  localparam int unsigned IDX_W   = 2;   // configuration register index
  localparam int unsigned SLOTS   = 3;   // results one pixel can release
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned HIST_N  = 4;   // pixels kept behind the current one

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [DIM_W-1:0]  MAX_WIDTH       = 13'd4096;
  localparam logic [DIM_W-1:0]  MAX_HEIGHT      = 13'd4096;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd100;
  localparam logic [DIM_W-1:0]  WIDTH_RESET     = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 13'd480;
  localparam logic [CNT_W-1:0]  EDGE            = 12'd2;
  localparam logic [CNT_W-1:0]  INNER_COL       = 12'd4;

  typedef enum logic [IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] threshold;
    logic [DIM_W-1:0]  frame_width;   // kept clamped to 1..MAX_WIDTH
    logic [DIM_W-1:0]  frame_height;  // kept clamped to 1..MAX_HEIGHT
  } cfg_t;

  // Results released by one input pixel, in output order.
  typedef struct packed {
    logic [SLOTS-1:0][DATA_W-1:0] pix;
    logic [SLOT_W-1:0]            cnt;      // 1..3 valid slots
    logic                         row_end;  // last slot closes the row
  } bundle_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/bayer_dead_pixel_correct.sv @@
// ----------------------------------------------------------------------------
// bayer_dead_pixel_correct
// Bayer dead pixel correction on a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Input stream: one Bayer pixel per transfer with its aligned defect mask
// level. A pixel whose level reaches the threshold is dead and, away from the
// two outer rows and columns, is replaced by the mean of its same-color
// neighbors two columns left and right when neither of those is dead.
// Output stream: the pixels in the same order, two pixels behind the input;
// tlast marks the last pixel of a row, and the row's final input transfer
// flushes the two held pixels, so it releases up to three results.
// Throughput: one pixel per cycle sustained while the queue is not full. The
// row-end burst of three results drains through a four-entry bundle queue
// during the first two pixels of the next row, which release nothing.
// A result is written into the queue by the transfer that releases it and is
// then loaded into the output register.
// Reset: threshold 100, 640 x 480 frame, position at row 0 column 0.
// Configuration writes take effect at once and belong in idle time.
// Receiver stall: the output register holds; the queue fills and the input
// side deasserts tready only once four bundles are waiting.
// ----------------------------------------------------------------------------
module bayer_dead_pixel_correct (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [7:0] pixel_in, [15:8] mask_level
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] pixel_out
  output logic                         m_axis_tlast,   // row_end
  input  logic                         cfg_we_i,
  input  logic [bdpc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [bdpc_pkg::DIM_W-1:0]   cfg_data_i
);

  bdpc_pkg::cfg_t    cfg_q, cfg_d;
  bdpc_pkg::bundle_t push_data;
  bdpc_pkg::bundle_t head;
  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bdpc_pkg::cfg_idx_e'(cfg_idx_i))
        bdpc_pkg::CFG_THRESHOLD: begin
          cfg_d.threshold = cfg_data_i[bdpc_pkg::DATA_W-1:0];
        end
        bdpc_pkg::CFG_FRAME_WIDTH: begin
          cfg_d.frame_width = bdpc_pkg::clamp_dim(cfg_data_i, bdpc_pkg::MAX_WIDTH);
        end
        bdpc_pkg::CFG_FRAME_HEIGHT: begin
          cfg_d.frame_height = bdpc_pkg::clamp_dim(cfg_data_i, bdpc_pkg::MAX_HEIGHT);
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= bdpc_pkg::THRESHOLD_RESET;
      cfg_q.frame_width  <= bdpc_pkg::WIDTH_RESET;
      cfg_q.frame_height <= bdpc_pkg::HEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bdpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .pixel_in_i   (s_axis_tdata[7:0]),
    .mask_level_i (s_axis_tdata[15:8]),
    .full_i       (full),
    .push_o       (push),
    .bundle_o     (push_data)
  );

  bdpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  bdpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pixel_out_o  (m_axis_tdata),
    .row_end_o    (m_axis_tlast)
  );

  // a bundle is never offered to a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("bundle pushed into full queue");

  // the back end only releases a bundle that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("pop from empty queue");

  // queued bundles always carry at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_valid |-> head.cnt != 2'd0)
    else $error("empty bundle in queue");

  // frame geometry stays inside the supported range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.frame_width != '0) && (cfg_q.frame_width <= bdpc_pkg::MAX_WIDTH) &&
    (cfg_q.frame_height != '0) && (cfg_q.frame_height <= bdpc_pkg::MAX_HEIGHT))
    else $error("frame geometry out of range");

endmodule

@@ rtl/bdpc_front.sv @@
// ----------------------------------------------------------------------------
// bdpc_front
// Accepts pixels, flags dead ones, tracks position and builds result bundles.
// ----------------------------------------------------------------------------
module bdpc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdpc_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdpc_pkg::DATA_W-1:0]   pixel_in_i,
  input  logic [bdpc_pkg::DATA_W-1:0]   mask_level_i,
  input  logic                          full_i,
  output logic                          push_o,
  output bdpc_pkg::bundle_t             bundle_o
);

  logic [bdpc_pkg::HIST_N-1:0][bdpc_pkg::DATA_W-1:0] hist_q, hist_d;
  logic [bdpc_pkg::HIST_N-1:0]                       dflag_q, dflag_d;
  logic [bdpc_pkg::CNT_W-1:0]                        col_q, col_d;
  logic [bdpc_pkg::CNT_W-1:0]                        row_q, row_d;

  logic                          accept;
  logic                          dead;
  logic                          last;
  logic                          row_inner;
  logic                          corr;
  logic [bdpc_pkg::DATA_W:0]     sum;
  logic [bdpc_pkg::DATA_W-1:0]   mid_pix;
  logic [bdpc_pkg::DIM_W-1:0]    col_next;
  logic [bdpc_pkg::DIM_W-1:0]    row_next;
  logic [bdpc_pkg::DIM_W-1:0]    row_far;
  bdpc_pkg::bundle_t             bundle;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    dead      = mask_level_i >= cfg_i.threshold;
    col_next  = {1'b0, col_q} + 13'd1;
    row_next  = {1'b0, row_q} + 13'd1;
    row_far   = {1'b0, row_q} + {1'b0, bdpc_pkg::EDGE};
    last      = col_next >= cfg_i.frame_width;
    row_inner = (row_q >= bdpc_pkg::EDGE) && (row_far < cfg_i.frame_height);
    // column c-2 is dead, both same-color neighbors are good
    corr      = row_inner && (col_q >= bdpc_pkg::INNER_COL) && dflag_q[1] &&
                !dflag_q[3] && !dead;
    sum       = {1'b0, hist_q[3]} + {1'b0, pixel_in_i};
    mid_pix   = corr ? sum[bdpc_pkg::DATA_W:1] : hist_q[1];
  end

  always_comb begin
    bundle         = '0;
    bundle.row_end = last;
    priority if (col_q >= bdpc_pkg::EDGE) begin
      bundle.pix[0] = mid_pix;
      if (last) begin
        bundle.pix[1] = hist_q[0];
        bundle.pix[2] = pixel_in_i;
        bundle.cnt    = 2'd3;
      end else begin
        bundle.cnt    = 2'd1;
      end
    end else if (last && (col_q != '0)) begin
      bundle.pix[0] = hist_q[0];
      bundle.pix[1] = pixel_in_i;
      bundle.cnt    = 2'd2;
    end else if (last) begin
      bundle.pix[0] = pixel_in_i;
      bundle.cnt    = 2'd1;
    end else begin
      bundle.cnt    = 2'd0;
    end
  end

  // drop empty bundles: the first two pixels of a row release nothing
  assign push_o   = accept && (bundle.cnt != 2'd0);
  assign bundle_o = bundle;

  always_comb begin
    hist_d  = hist_q;
    dflag_d = dflag_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      hist_d  = {hist_q[bdpc_pkg::HIST_N-2:0], pixel_in_i};
      dflag_d = {dflag_q[bdpc_pkg::HIST_N-2:0], dead};
      if (last) begin
        col_d = '0;
        row_d = (row_next >= cfg_i.frame_height) ? '0 : row_next[bdpc_pkg::CNT_W-1:0];
      end else begin
        col_d = col_next[bdpc_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      dflag_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      hist_q  <= hist_d;
      dflag_q <= dflag_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

@@ rtl/bdpc_queue.sv @@
// ----------------------------------------------------------------------------
// bdpc_queue
// Short register queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module bdpc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bdpc_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output bdpc_pkg::bundle_t head_o
);

  bdpc_pkg::bundle_t                mem_q [bdpc_pkg::QUEUE_DEPTH];
  logic [bdpc_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bdpc_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bdpc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o       = cnt_q == bdpc_pkg::QCNT_W'(bdpc_pkg::QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/bdpc_back.sv @@
// ----------------------------------------------------------------------------
// bdpc_back
// Unpacks result bundles into single pixels behind an output register.
// ----------------------------------------------------------------------------
module bdpc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  bdpc_pkg::bundle_t             head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdpc_pkg::DATA_W-1:0]   pixel_out_o,
  output logic                          row_end_o
);

  logic [bdpc_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic                         valid_q, valid_d;
  logic [bdpc_pkg::DATA_W-1:0]  pix_q, pix_d;
  logic                         end_q, end_d;
  logic                         load;
  logic                         tail;

  assign load = !valid_q || out_ready_i;
  assign tail = idx_q == (head_i.cnt - 2'd1);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    pix_d   = pix_q;
    end_d   = end_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        pix_d = head_i.pix[idx_q];
        end_d = head_i.row_end && tail;
        // advance within the bundle, release it on its last slot
        if (tail) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    end_q <= end_d;
  end

  assign out_valid_o = valid_q;
  assign pixel_out_o = pix_q;
  assign row_end_o   = end_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bayer dead pixel correction stream.
// ----------------------------------------------------------------------------
// A queue of raw pixels feeds a bursty stream driver. Every accepted transfer
// runs through a local copy of the correction logic, and its outputs are
// queued. The monitor matches each output transfer against that queue. The
// run starts with hand-built rows (degenerate widths, a correction with
// truncation, a blocked correction). Random phases follow, with new threshold
// and geometry settings written between them, including clamped and
// oversized dimensions and geometry changes in the middle of a row.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [bdpc_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int unsigned RANDOM_PIXELS = 310;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [bdpc_pkg::DATA_W-1:0] pix;
    logic [bdpc_pkg::DATA_W-1:0] lvl;
  } raw_pixel_t;

  typedef struct packed {
    logic [bdpc_pkg::DATA_W-1:0] pix;
    logic                        row_end;
  } out_pixel_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;    // [7:0] pixel_in, [15:8] mask_level
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;         // [7:0] pixel_out
  logic                         m_axis_tlast;         // row_end
  logic                         cfg_we_i = 1'b0;
  logic [bdpc_pkg::IDX_W-1:0]   cfg_idx_i = '0;
  logic [bdpc_pkg::DIM_W-1:0]   cfg_data_i = '0;

  bayer_dead_pixel_correct dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Local copy of the block's registers and pipeline state
  logic [bdpc_pkg::DATA_W-1:0] thr_q;
  logic [bdpc_pkg::DIM_W-1:0]  frame_w_q;
  logic [bdpc_pkg::DIM_W-1:0]  frame_h_q;
  logic [bdpc_pkg::DATA_W-1:0] hist_pix [bdpc_pkg::HIST_N];
  bit                          hist_dead [bdpc_pkg::HIST_N];
  int unsigned                 col_cnt;
  int unsigned                 row_cnt;

  raw_pixel_t  raw_pixels[$];
  out_pixel_t  corrected_pixels[$];

  int unsigned pixels_queued;
  int unsigned pixels_accepted;
  int unsigned results_checked;
  int unsigned corrections;
  int unsigned rows_closed;
  int unsigned phases;
  int unsigned errors;

  // driver state
  raw_pixel_t  cur_pixel;
  bit          nxt_valid;
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver state
  bit          long_hold_req;
  bit          long_hold_done;
  int unsigned hold_left;
  int unsigned ready_mode;
  int unsigned mode_left;
  bit          nxt_ready;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic correct_pixel(input logic [bdpc_pkg::DATA_W-1:0] pix,
                               input logic [bdpc_pkg::DATA_W-1:0] lvl);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    bit dead;
    bit last;
    bit inner_row;
    logic [bdpc_pkg::DATA_W-1:0] v;
    logic [bdpc_pkg::DATA_W:0] sum;
    w = frame_w_q;
    h = frame_h_q;
    if (w == 0) w = 1;
    else if (w > bdpc_pkg::MAX_WIDTH) w = bdpc_pkg::MAX_WIDTH;
    if (h == 0) h = 1;
    else if (h > bdpc_pkg::MAX_HEIGHT) h = bdpc_pkg::MAX_HEIGHT;
    dead = (lvl >= thr_q);
    c = col_cnt;
    last = (c + 1 >= w);
    if (c >= bdpc_pkg::EDGE) begin
      // column c-2 sits in slot 1; its neighbors are slot 3 and the new pixel
      v = hist_pix[1];
      inner_row = (row_cnt >= bdpc_pkg::EDGE) && (row_cnt + bdpc_pkg::EDGE < h);
      if (inner_row && c >= bdpc_pkg::INNER_COL && hist_dead[1] && !hist_dead[3] &&
          !dead) begin
        sum = {1'b0, hist_pix[3]} + {1'b0, pix};
        v = sum[bdpc_pkg::DATA_W:1];
        corrections++;
      end
      corrected_pixels.push_back('{pix: v, row_end: 1'b0});
    end
    if (last) begin
      if (c >= 1) corrected_pixels.push_back('{pix: hist_pix[0], row_end: 1'b0});
      corrected_pixels.push_back('{pix: pix, row_end: 1'b1});
    end
    for (int i = bdpc_pkg::HIST_N - 1; i > 0; i--) begin
      hist_pix[i] = hist_pix[i-1];
      hist_dead[i] = hist_dead[i-1];
    end
    hist_pix[0] = pix;
    hist_dead[0] = dead;
    if (last) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // Stream driver: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        correct_pixel(cur_pixel.pix, cur_pixel.lvl);
        pixels_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (raw_pixels.size() > 0) begin
          cur_pixel = raw_pixels.pop_front();
          nxt_valid = 1'b1;
          s_axis_tdata <= {cur_pixel.lvl, cur_pixel.pix};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_axis_tvalid <= nxt_valid;
      end
    end
  end

  // Output side: stall pattern of its own, plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = 150;
      nxt_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(4, 40);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       nxt_ready = 1'b1;
        1:       nxt_ready = 1'($urandom_range(0, 1));
        2:       nxt_ready = ($urandom_range(0, 3) == 0);
        default: nxt_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
    m_axis_tready <= nxt_ready;
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (corrected_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel %0d row_end %0b", $time,
                 m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        if (m_axis_tdata !== corrected_pixels[0].pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   corrected_pixels[0].pix, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== corrected_pixels[0].row_end) begin
          $display("%0t: row_end expected %0b actual %0b", $time,
                   corrected_pixels[0].row_end, m_axis_tlast);
          errors++;
        end
        if (corrected_pixels[0].row_end) rows_closed++;
        void'(corrected_pixels.pop_front());
        results_checked++;
      end
    end
  end

  task automatic write_reg(input logic [bdpc_pkg::IDX_W-1:0] idx,
                           input logic [bdpc_pkg::DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      bdpc_pkg::CFG_THRESHOLD:    thr_q = val[bdpc_pkg::DATA_W-1:0];
      bdpc_pkg::CFG_FRAME_WIDTH:  frame_w_q = val;
      bdpc_pkg::CFG_FRAME_HEIGHT: frame_h_q = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [bdpc_pkg::DATA_W-1:0] pix,
                             input logic [bdpc_pkg::DATA_W-1:0] lvl);
    raw_pixels.push_back('{pix: pix, lvl: lvl});
    pixels_queued++;
  endtask

  // Hold until every pixel went in and every output came back, then settle;
  // sample between edges so the driver's updates have landed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (raw_pixels.size() != 0 || s_axis_tvalid || corrected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    phases++;
  endtask

  function automatic logic [bdpc_pkg::DIM_W-1:0] pick_dim(input int unsigned hi);
    case ($urandom_range(0, 11))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd2;
      3:       return 13'd3;
      4:       return 13'd4;
      5:       return 13'h1FFF;
      6:       return 13'd4096;
      7:       return 13'd4097;
      default: return 13'($urandom_range(5, hi));
    endcase
  endfunction

  function automatic logic [bdpc_pkg::DIM_W-1:0] pick_threshold();
    logic [bdpc_pkg::DIM_W-1:0] t;
    case ($urandom_range(0, 5))
      0:       t = 13'd0;
      1:       t = 13'd255;
      default: t = 13'($urandom_range(1, 254));
    endcase
    // upper data bits must not leak into the threshold
    t[bdpc_pkg::DIM_W-1:bdpc_pkg::DATA_W] = 5'($urandom_range(0, 31));
    return t;
  endfunction

  initial begin
    int unsigned n;
    int unsigned dead_pct;
    int unsigned lvl;
    logic [bdpc_pkg::DATA_W-1:0] pix;

    thr_q = bdpc_pkg::THRESHOLD_RESET;
    frame_w_q = bdpc_pkg::WIDTH_RESET;
    frame_h_q = bdpc_pkg::HEIGHT_RESET;
    for (int i = 0; i < bdpc_pkg::HIST_N; i++) begin
      hist_pix[i] = '0;
      hist_dead[i] = 1'b0;
    end
    col_cnt = 0;
    row_cnt = 0;
    burst_left = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Width and height zero act as one; threshold zero marks everything dead
    write_reg(CFG_SPARE, 13'h1FFF);
    write_reg(bdpc_pkg::CFG_THRESHOLD, 13'h1F00);
    write_reg(bdpc_pkg::CFG_FRAME_WIDTH, 13'd0);
    write_reg(bdpc_pkg::CFG_FRAME_HEIGHT, 13'd0);
    queue_pixel(8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF);
    wait_idle();

    // Two-pixel rows flush both pixels on the row end
    write_reg(bdpc_pkg::CFG_THRESHOLD, 13'd255);
    write_reg(bdpc_pkg::CFG_FRAME_WIDTH, 13'd2);
    queue_pixel(8'h55, 8'hAA);
    queue_pixel(8'hAA, 8'h55);
    wait_idle();

    // 5x6 frame: row 2 corrects its center with truncation, row 3 is blocked
    // by a dead left neighbor; levels sit one below and at the threshold
    write_reg(bdpc_pkg::CFG_THRESHOLD, 13'd200);
    write_reg(bdpc_pkg::CFG_FRAME_WIDTH, 13'd5);
    write_reg(bdpc_pkg::CFG_FRAME_HEIGHT, 13'd6);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 5; c++) begin
        pix = (c == 0) ? 8'd10 : (c == 4) ? 8'd31 : 8'(100 + r * 5 + c);
        lvl = 199;
        if (c == 2 && r >= 2) lvl = 200;
        if (c == 0 && r == 3) lvl = 255;
        queue_pixel(pix, 8'(lvl));
      end
    end
    wait_idle();

    for (int unsigned ph = 0; pixels_queued < RANDOM_PIXELS; ph++) begin
      case (ph)
        0: begin
          write_reg(bdpc_pkg::CFG_THRESHOLD, 13'd255);
          write_reg(bdpc_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
          write_reg(bdpc_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
        end
        1: begin
          write_reg(bdpc_pkg::CFG_THRESHOLD, 13'd0);
          write_reg(bdpc_pkg::CFG_FRAME_WIDTH, 13'd4096);
          write_reg(bdpc_pkg::CFG_FRAME_HEIGHT, 13'd4096);
        end
        default: begin
          write_reg(bdpc_pkg::CFG_THRESHOLD, pick_threshold());
          if ($urandom_range(0, 3) != 0) write_reg(bdpc_pkg::CFG_FRAME_WIDTH, pick_dim(12));
          if ($urandom_range(0, 3) != 0) write_reg(bdpc_pkg::CFG_FRAME_HEIGHT, pick_dim(8));
        end
      endcase
      n = (ph == 3) ? 60 : $urandom_range(20, 50);
      case ($urandom_range(0, 2))
        0:       dead_pct = 10;
        1:       dead_pct = 25;
        default: dead_pct = 50;
      endcase
      for (int unsigned k = 0; k < n; k++) begin
        if (thr_q == 0 || $urandom_range(0, 99) < dead_pct) lvl = $urandom_range(thr_q, 255);
        else lvl = $urandom_range(0, thr_q - 1);
        queue_pixel(8'($urandom_range(0, 255)), 8'(lvl));
      end
      // let the output side hold off while this long phase keeps streaming
      if (ph == 3) begin
        @(negedge clk_i);
        long_hold_req = 1'b1;
      end
      wait_idle();
    end

    $display("summary: %0d pixels over %0d phases, %0d outputs checked, %0d rows closed",
             pixels_accepted, phases, results_checked, rows_closed);
    $display("summary: %0d dead pixels replaced, long output stall %0s",
             corrections, long_hold_done ? "applied" : "skipped");
    if (errors == 0 && corrected_pixels.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d outputs outstanding", $time, corrected_pixels.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
